FILE: src/ddo_pkg.sv
// Package for the differential drive odometry block: constants, state codes, CORDIC angle table.
`default_nettype none
package ddo_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int COUNT_WIDTH     = 32;
  localparam int CORDIC_STEPS    = 30;
  localparam int CORDIC_GAIN     = 652032874;
  localparam int TURN_PER_RADIAN = 683565276;
  localparam int USEC_PER_SEC    = 1000000;
  localparam int DIV_BITS        = 112;
  localparam int POSE_SHIFT      = 62 - FRAC_BITS;
  localparam int SPEED_SHIFT     = 32 - FRAC_BITS;
  localparam int COUNT_SHIFT     = 32 - COUNT_WIDTH;
  localparam int RADIUS_SHIFT    = 15;

  localparam logic [2:0] REG_MPT  = 3'd0;
  localparam logic [2:0] REG_AXLE = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CALC, ST_MUL, ST_DIV, ST_COR, ST_SAVE, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    SP_LMAGL, SP_LMAGR, SP_SMAG, SP_DMAG,
    SP_SPDL_M, SP_SPDL_D, SP_SPDR_M, SP_SPDR_D,
    SP_COR0, SP_TURN_M, SP_TURN_D, SP_RAD_M, SP_RAD_D, SP_COR1,
    SP_STEPX, SP_STEPY
  } step_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: src/diff_drive_odometry.sv
// Differential drive wheel odometry: arc model pose tracker on a shared multiply/divide/CORDIC datapath.
//
//   channel  | signals                                      | accepted when
//   ---------+----------------------------------------------+------------------------------
//   input    | in_left_count, in_right_count, in_elapsed_us | in_valid & in_ready
//   result   | out_pose_*, out_vel_*, out_speed_invalid     | out_valid & out_ready
//   config   | psel penable pwrite paddr pwdata prdata      | psel & penable & pwrite
//
// The next request can be taken in the same cycle that out_valid rises. Zero elapsed time
// skips both speed divides. The 112-step restoring divider dominates the run time: two speed
// divides, plus turn and radius on an arc. in_ready is high only while the sequencer is idle.
// One finished result may wait in the output register while the next request is taken. A
// second finished result holds in the last sequencer state until out_ready frees the register.
// Synchronous active-low reset clears the pose, the previous counts and the registers to their
// defaults.
`default_nettype none
module diff_drive_odometry
  import ddo_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  signed [31:0] in_left_count,
  input  wire  signed [31:0] in_right_count,
  input  wire         [23:0] in_elapsed_us,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [31:0] out_pose_x,
  output logic signed [31:0] out_pose_y,
  output logic signed [31:0] out_pose_heading,
  output logic signed [31:0] out_vel_left,
  output logic signed [31:0] out_vel_right,
  output logic               out_speed_invalid,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire         [2:0]  paddr,
  input  wire         [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  localparam logic [33:0] GAIN34 = 34'(CORDIC_GAIN);
  localparam logic [33:0] TPR34  = 34'(TURN_PER_RADIAN);
  localparam logic [33:0] USEC34 = 34'(USEC_PER_SEC);
  localparam logic [6:0]  DIV_LAST = 7'(DIV_BITS - 1);
  localparam logic [6:0]  COR_LAST = 7'(CORDIC_STEPS - 1);

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [31:0] mpt_r, axle_r;
  logic [31:0] prev_l_r, prev_l_nxt, prev_rt_r, prev_rt_nxt;
  logic [31:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt, head_r, head_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic signed [31:0] dl_r, dl_nxt, dr_r, dr_nxt;
  logic [23:0] el_r, el_nxt;
  logic [63:0] lmagl_r, lmagl_nxt, lmagr_r, lmagr_nxt;
  logic [63:0] smag_r, smag_nxt, dmag_r, dmag_nxt, rad_r, rad_nxt;
  logic [31:0] turn_r, turn_nxt, ls_r, ls_nxt, rs_r, rs_nxt;
  logic signed [41:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [33:0] c0_r, c0_nxt, s0_r, s0_nxt, c1_r, c1_nxt, s1_r, s1_nxt;
  logic signed [33:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic        flip_r, flip_nxt;
  logic [63:0] wa_r, wa_nxt;
  logic [33:0] wb_r, wb_nxt;
  logic [65:0] prod_r, prod_nxt;
  logic [111:0] acc_r, acc_nxt;
  logic [63:0] den_r, den_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic signed [31:0] ox_r, ox_nxt, oy_r, oy_nxt, oh_r, oh_nxt;
  logic signed [31:0] ols_r, ols_nxt, ors_r, ors_nxt;
  logic        oinv_r, oinv_nxt;

  logic [31:0] dl_raw, dr_raw, dl_mag;
  logic signed [31:0] dl_new, dr_new;
  logic signed [32:0] st, dt;
  logic [32:0] st_mag, dt_mag;
  logic        straight;
  logic [31:0] axle_eff;
  logic [31:0] mul_x;
  logic [65:0] mul_p;
  logic [64:0] div_t, div_d;
  logic        div_ge;
  logic signed [33:0] xs, ys, at;
  logic [31:0] cor_ang, cor_za;
  logic        cor_flip;
  logic signed [34:0] trig, trig_abs;
  logic [33:0] trig_mag;
  logic        neg_base, step_sign, p_over;
  logic [111:0] p;
  logic [40:0] v;
  logic signed [41:0] step_val;
  logic        spd_neg, spd_over;
  logic [31:0] spd_mag, spd_val;
  logic signed [42:0] sum_x, sum_y;

  assign pready    = 1'b1;
  assign prdata    = (paddr == REG_AXLE) ? axle_r : mpt_r;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_pose_x = ox_r;
  assign out_pose_y = oy_r;
  assign out_pose_heading = oh_r;
  assign out_vel_left   = ols_r;
  assign out_vel_right  = ors_r;
  assign out_speed_invalid = oinv_r;

  function automatic logic signed [31:0] sat43(input logic signed [42:0] s);
    logic signed [31:0] r;
    if (s > 43'sd2147483647) r = 32'h7fffffff;
    else if (s < -43'sd2147483648) r = 32'h80000000;
    else r = s[31:0];
    return r;
  endfunction

  always_comb begin
    // wrap count differences to COUNT_WIDTH and read as signed
    dl_raw = in_left_count - prev_l_r;
    dr_raw = in_right_count - prev_rt_r;
    dl_new = $signed(dl_raw << COUNT_SHIFT) >>> COUNT_SHIFT;
    dr_new = $signed(dr_raw << COUNT_SHIFT) >>> COUNT_SHIFT;
    st = {dl_r[31], dl_r} + {dr_r[31], dr_r};
    dt = {dr_r[31], dr_r} - {dl_r[31], dl_r};
    st_mag = st[32] ? 33'(-st) : 33'(st);
    dt_mag = dt[32] ? 33'(-dt) : 33'(dt);
    dl_mag = dl_r[31] ? 32'(-dl_r) : 32'(dl_r);
    straight = (dmag_r == 64'd0);
    axle_eff = (axle_r == 32'd0) ? 32'd1 : axle_r;

    mul_x = cnt_r[0] ? wa_r[63:32] : wa_r[31:0];
    mul_p = {34'd0, mul_x} * {32'd0, wb_r};

    div_t  = {rem_r, acc_r[111]};
    div_ge = (div_t >= {1'b0, den_r});
    div_d  = div_t - {1'b0, den_r};

    xs = cx_r >>> cnt_r[4:0];
    ys = cy_r >>> cnt_r[4:0];
    at = $signed({2'b00, atan_bam(cnt_r[4:0])});

    // fold the back half circle onto the front and negate the results
    cor_ang  = (step_r == SP_COR0) ? head_r : head_r + turn_r;
    cor_flip = cor_ang[31] ^ cor_ang[30];
    cor_za   = cor_ang ^ {cor_flip, 31'd0};

    if (straight) begin
      trig = (step_r == SP_STEPX) ? 35'(c0_r) : 35'(s0_r);
    end else begin
      trig = (step_r == SP_STEPX) ? 35'(s1_r) - 35'(s0_r) : 35'(c1_r) - 35'(c0_r);
    end
    trig_abs = trig[34] ? -trig : trig;
    trig_mag = trig_abs[33:0];

    neg_base  = straight ? dl_r[31] : (st[32] != dt[32]);
    step_sign = neg_base ^ trig[34] ^ (!straight && step_r == SP_STEPY);
    p      = acc_r >> POSE_SHIFT;
    p_over = (p > (112'd1 << 40));
    v      = p_over ? (41'd1 << 40) : p[40:0];
    step_val = step_sign ? -$signed({1'b0, v}) : $signed({1'b0, v});

    spd_neg  = (step_r == SP_SPDL_D) ? dl_r[31] : dr_r[31];
    spd_over = spd_neg ? (acc_r > 112'h8000_0000) : (acc_r > 112'h7fff_ffff);
    spd_mag  = spd_over ? (spd_neg ? 32'h8000_0000 : 32'h7fff_ffff) : acc_r[31:0];
    spd_val  = spd_neg ? 32'd0 - spd_mag : spd_mag;

    sum_x = $signed({{11{pos_x_r[31]}}, pos_x_r}) + $signed({dx_r[41], dx_r});
    sum_y = $signed({{11{pos_y_r[31]}}, pos_y_r}) + $signed({dy_r[41], dy_r});

    state_nxt = state_r;  step_nxt = step_r;  cnt_nxt = cnt_r;
    prev_l_nxt = prev_l_r;  prev_rt_nxt = prev_rt_r;
    pos_x_nxt = pos_x_r;  pos_y_nxt = pos_y_r;  head_nxt = head_r;
    out_valid_nxt = out_valid_r && !out_ready;
    dl_nxt = dl_r;  dr_nxt = dr_r;  el_nxt = el_r;
    lmagl_nxt = lmagl_r;  lmagr_nxt = lmagr_r;  smag_nxt = smag_r;  dmag_nxt = dmag_r;
    rad_nxt = rad_r;  turn_nxt = turn_r;  ls_nxt = ls_r;  rs_nxt = rs_r;
    dx_nxt = dx_r;  dy_nxt = dy_r;
    c0_nxt = c0_r;  s0_nxt = s0_r;  c1_nxt = c1_r;  s1_nxt = s1_r;
    cx_nxt = cx_r;  cy_nxt = cy_r;  cz_nxt = cz_r;  flip_nxt = flip_r;
    wa_nxt = wa_r;  wb_nxt = wb_r;  prod_nxt = prod_r;  acc_nxt = acc_r;
    den_nxt = den_r;  rem_nxt = rem_r;
    ox_nxt = ox_r;  oy_nxt = oy_r;  oh_nxt = oh_r;
    ols_nxt = ols_r;  ors_nxt = ors_r;  oinv_nxt = oinv_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          dl_nxt = dl_new;
          dr_nxt = dr_new;
          el_nxt = in_elapsed_us;
          prev_l_nxt  = in_left_count;
          prev_rt_nxt = in_right_count;
          step_nxt  = SP_LMAGL;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        cnt_nxt = 7'd0;
        rem_nxt = 64'd0;
        case (step_r)
          SP_LMAGL: begin
            wa_nxt = {32'd0, dl_mag};  wb_nxt = {2'b00, mpt_r};  state_nxt = ST_MUL;
          end
          SP_LMAGR: begin
            wa_nxt = {32'd0, (dr_r[31] ? 32'(-dr_r) : 32'(dr_r))};
            wb_nxt = {2'b00, mpt_r};  state_nxt = ST_MUL;
          end
          SP_SMAG: begin
            wa_nxt = {31'd0, st_mag};  wb_nxt = {2'b00, mpt_r};  state_nxt = ST_MUL;
          end
          SP_DMAG: begin
            wa_nxt = {31'd0, dt_mag};  wb_nxt = {2'b00, mpt_r};  state_nxt = ST_MUL;
          end
          SP_SPDL_M: begin
            if (el_r == 24'd0) begin
              ls_nxt = 32'd0;  step_nxt = SP_SPDR_M;
            end else begin
              wa_nxt = lmagl_r;  wb_nxt = USEC34;  state_nxt = ST_MUL;
            end
          end
          SP_SPDR_M: begin
            if (el_r == 24'd0) begin
              rs_nxt = 32'd0;  step_nxt = SP_COR0;
            end else begin
              wa_nxt = lmagr_r;  wb_nxt = USEC34;  state_nxt = ST_MUL;
            end
          end
          SP_SPDL_D, SP_SPDR_D: begin
            den_nxt = {40'd0, el_r} << SPEED_SHIFT;  state_nxt = ST_DIV;
          end
          SP_TURN_M: begin
            wa_nxt = dmag_r;  wb_nxt = TPR34;  state_nxt = ST_MUL;
          end
          SP_TURN_D: begin
            den_nxt = {16'd0, axle_eff, 16'd0};  state_nxt = ST_DIV;
          end
          SP_RAD_M: begin
            wa_nxt = smag_r;  wb_nxt = {2'b00, axle_eff};  state_nxt = ST_MUL;
          end
          SP_RAD_D: begin
            acc_nxt = acc_r << RADIUS_SHIFT;  den_nxt = dmag_r;  state_nxt = ST_DIV;
          end
          SP_COR0, SP_COR1: begin
            cx_nxt = $signed(GAIN34);
            cy_nxt = 34'sd0;
            cz_nxt = $signed({{2{cor_za[31]}}, cor_za});
            flip_nxt  = cor_flip;
            state_nxt = ST_COR;
          end
          SP_STEPX, SP_STEPY: begin
            wa_nxt = straight ? lmagl_r : rad_r;  wb_nxt = trig_mag;  state_nxt = ST_MUL;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_MUL: begin
        // low half, then high half shifted into the accumulator
        case (cnt_r[1:0])
          2'd0: begin
            prod_nxt = mul_p;  cnt_nxt = 7'd1;
          end
          2'd1: begin
            acc_nxt = {46'd0, prod_r};  prod_nxt = mul_p;  cnt_nxt = 7'd2;
          end
          default: begin
            acc_nxt = acc_r + {14'd0, prod_r, 32'd0};  state_nxt = ST_SAVE;
          end
        endcase
      end
      ST_DIV: begin
        rem_nxt = div_ge ? div_d[63:0] : div_t[63:0];
        acc_nxt = {acc_r[110:0], div_ge};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == DIV_LAST) state_nxt = ST_SAVE;
      end
      ST_COR: begin
        if (!cz_r[33]) begin
          cx_nxt = cx_r - ys;  cy_nxt = cy_r + xs;  cz_nxt = cz_r - at;
        end else begin
          cx_nxt = cx_r + ys;  cy_nxt = cy_r - xs;  cz_nxt = cz_r + at;
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == COR_LAST) state_nxt = ST_SAVE;
      end
      ST_SAVE: begin
        state_nxt = ST_CALC;
        case (step_r)
          SP_LMAGL:  begin lmagl_nxt = acc_r[63:0];  step_nxt = SP_LMAGR;  end
          SP_LMAGR:  begin lmagr_nxt = acc_r[63:0];  step_nxt = SP_SMAG;   end
          SP_SMAG:   begin smag_nxt  = acc_r[63:0];  step_nxt = SP_DMAG;   end
          SP_DMAG:   begin dmag_nxt  = acc_r[63:0];  step_nxt = SP_SPDL_M; end
          SP_SPDL_M: step_nxt = SP_SPDL_D;
          SP_SPDL_D: begin ls_nxt = spd_val;  step_nxt = SP_SPDR_M; end
          SP_SPDR_M: step_nxt = SP_SPDR_D;
          SP_SPDR_D: begin rs_nxt = spd_val;  step_nxt = SP_COR0; end
          SP_COR0: begin
            c0_nxt = flip_r ? -cx_r : cx_r;
            s0_nxt = flip_r ? -cy_r : cy_r;
            step_nxt = straight ? SP_STEPX : SP_TURN_M;
          end
          SP_TURN_M: step_nxt = SP_TURN_D;
          SP_TURN_D: begin
            turn_nxt = dt[32] ? 32'd0 - acc_r[31:0] : acc_r[31:0];
            step_nxt = SP_RAD_M;
          end
          SP_RAD_M: step_nxt = SP_RAD_D;
          SP_RAD_D: begin
            rad_nxt  = (|acc_r[111:63]) ? 64'h7fff_ffff_ffff_ffff : acc_r[63:0];
            step_nxt = SP_COR1;
          end
          SP_COR1: begin
            c1_nxt = flip_r ? -cx_r : cx_r;
            s1_nxt = flip_r ? -cy_r : cy_r;
            step_nxt = SP_STEPX;
          end
          SP_STEPX: begin dx_nxt = step_val;  step_nxt = SP_STEPY; end
          SP_STEPY: begin dy_nxt = step_val;  state_nxt = ST_DONE; end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          pos_x_nxt = sat43(sum_x);
          pos_y_nxt = sat43(sum_y);
          if (!straight) head_nxt = head_r + turn_r;
          ox_nxt  = sat43(sum_x);
          oy_nxt  = sat43(sum_y);
          oh_nxt  = straight ? head_r : head_r + turn_r;
          ols_nxt = ls_r;
          ors_nxt = rs_r;
          oinv_nxt = (el_r == 24'd0);
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= SP_LMAGL;
      cnt_r   <= 7'd0;
      mpt_r   <= 32'd429497;
      axle_r  <= 32'd39322;
      prev_l_r  <= 32'd0;
      prev_rt_r <= 32'd0;
      pos_x_r <= 32'd0;
      pos_y_r <= 32'd0;
      head_r  <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      prev_l_r  <= prev_l_nxt;
      prev_rt_r <= prev_rt_nxt;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      head_r  <= head_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite) begin
        if (paddr == REG_AXLE) axle_r <= pwdata;
        else if (paddr == REG_MPT) mpt_r <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    dl_r <= dl_nxt;  dr_r <= dr_nxt;  el_r <= el_nxt;
    lmagl_r <= lmagl_nxt;  lmagr_r <= lmagr_nxt;
    smag_r <= smag_nxt;  dmag_r <= dmag_nxt;  rad_r <= rad_nxt;
    turn_r <= turn_nxt;  ls_r <= ls_nxt;  rs_r <= rs_nxt;
    dx_r <= dx_nxt;  dy_r <= dy_nxt;
    c0_r <= c0_nxt;  s0_r <= s0_nxt;  c1_r <= c1_nxt;  s1_r <= s1_nxt;
    cx_r <= cx_nxt;  cy_r <= cy_nxt;  cz_r <= cz_nxt;  flip_r <= flip_nxt;
    wa_r <= wa_nxt;  wb_r <= wb_nxt;  prod_r <= prod_nxt;  acc_r <= acc_nxt;
    den_r <= den_nxt;  rem_r <= rem_nxt;
    ox_r <= ox_nxt;  oy_r <= oy_nxt;  oh_r <= oh_nxt;
    ols_r <= ols_nxt;  ors_r <= ors_nxt;  oinv_r <= oinv_nxt;
  end

endmodule
`default_nettype wire

FILE: tb/ddo_checker.sv
// Checker for diff_drive_odometry: watches the channels, predicts each pose and compares.
`timescale 1ns / 1ps
module ddo_checker
  import ddo_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_ready,
  input  wire signed [31:0] in_left_count,
  input  wire signed [31:0] in_right_count,
  input  wire        [23:0] in_elapsed_us,
  input  wire               out_valid,
  input  wire               out_ready,
  input  wire signed [31:0] out_pose_x,
  input  wire signed [31:0] out_pose_y,
  input  wire signed [31:0] out_pose_heading,
  input  wire signed [31:0] out_vel_left,
  input  wire signed [31:0] out_vel_right,
  input  wire               out_speed_invalid,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire        [2:0]  paddr,
  input  wire        [31:0] pwdata,
  input  wire               pready,
  output int                pending,
  output int                errors
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] hdg;
    logic [31:0] lspd;
    logic [31:0] rspd;
    logic        no_time;
  } pose_t;

  localparam logic [31:0] ARCTAN [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };
  localparam logic [63:0] STEP_CAP = 64'd1 << 40;

  logic [31:0] mpt, axle;
  logic [31:0] last_l, last_r, px, py, hdg;
  pose_t       pose_q[$];

  function automatic logic [63:0] magn(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic void sincos(input logic [31:0] ang, output longint c, output longint s);
    logic   flip;
    longint x, y, z, xs, ys;
    flip = ang[31] ^ ang[30];
    if (flip) ang = ang ^ 32'h80000000;
    x = CORDIC_GAIN;
    y = 0;
    z = longint'(signed'(ang));
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ARCTAN[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ARCTAN[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint pose_inc(input logic [63:0] m, input bit neg, input longint trig);
    logic [127:0] p;
    logic [63:0]  v;
    p = (128'(m) * 128'(magn(trig))) >> POSE_SHIFT;
    v = (p > 128'(STEP_CAP)) ? STEP_CAP : p[63:0];
    return (neg != (trig < 0)) ? -longint'(v) : longint'(v);
  endfunction

  function automatic logic [31:0] wheel_rate(input longint t, input logic [23:0] el);
    logic [63:0]  m, cap;
    logic [127:0] q;
    if (el == 0) return 32'd0;
    m = magn(t) * 64'(mpt);
    q = (128'(m) * 128'(USEC_PER_SEC)) / (128'(el) << SPEED_SHIFT);
    cap = t < 0 ? 64'h80000000 : 64'h7FFFFFFF;
    if (q[127:64] != 0 || q[63:0] > cap) q = 128'(cap);
    return t < 0 ? -q[31:0] : q[31:0];
  endfunction

  // advance the tracked pose by one request and return the expected result
  function automatic pose_t track(input logic [31:0] lc, input logic [31:0] rc,
                                  input logic [23:0] el);
    pose_t        r;
    longint       dl, dr, st, df, c0, s0, c1, s1, dx, dy;
    logic [63:0]  ax, smag, dmag, lmag, rad;
    logic [127:0] q;
    logic [31:0]  turn;
    bit           neg;
    dl = longint'(signed'(lc - last_l));
    dr = longint'(signed'(rc - last_r));
    st = dl + dr;
    df = dr - dl;
    ax = (axle == 0) ? 64'd1 : 64'(axle);
    smag = magn(st) * 64'(mpt);
    dmag = magn(df) * 64'(mpt);
    r.lspd = wheel_rate(dl, el);
    r.rspd = wheel_rate(dr, el);
    r.no_time = (el == 0);
    last_l = lc;
    last_r = rc;
    sincos(hdg, c0, s0);
    if (dmag == 0) begin
      lmag = magn(dl) * 64'(mpt);
      dx = pose_inc(lmag, dl < 0, c0);
      dy = pose_inc(lmag, dl < 0, s0);
    end else begin
      q = (128'(dmag) * 128'(TURN_PER_RADIAN)) / (128'(ax) << 16);
      turn = q[31:0];
      if (df < 0) turn = -turn;
      q = ((128'(smag) * 128'(ax)) << RADIUS_SHIFT) / 128'(dmag);
      rad = (q > 128'h7FFFFFFFFFFFFFFF) ? 64'h7FFFFFFFFFFFFFFF : q[63:0];
      sincos(hdg + turn, c1, s1);
      neg = (st < 0) != (df < 0);
      dx = pose_inc(rad, neg, s1 - s0);
      dy = -pose_inc(rad, neg, c1 - c0);
      hdg = hdg + turn;
    end
    px = clamp32(longint'(signed'(px)) + dx);
    py = clamp32(longint'(signed'(py)) + dy);
    r.x = px;
    r.y = py;
    r.hdg = hdg;
    return r;
  endfunction

  assign pending = pose_q.size();

  always @(posedge clk) begin
    pose_t e;
    if (!rst_n) begin
      mpt <= 32'd429497;
      axle <= 32'd39322;
      last_l = 0; last_r = 0; px = 0; py = 0; hdg = 0;
      pose_q.delete();
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == REG_MPT) mpt <= pwdata;
        else if (paddr == REG_AXLE) axle <= pwdata;
      end
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          $error("result with no request outstanding");
          errors <= errors + 1;
        end else begin
          int bad;
          bad = 0;
          e = pose_q.pop_front();
          if (out_pose_x !== e.x) begin
            $error("pose_x: expected %0d, got %0d", signed'(e.x), out_pose_x); bad++;
          end
          if (out_pose_y !== e.y) begin
            $error("pose_y: expected %0d, got %0d", signed'(e.y), out_pose_y); bad++;
          end
          if (out_pose_heading !== e.hdg) begin
            $error("pose_heading: expected %0d, got %0d", signed'(e.hdg), out_pose_heading);
            bad++;
          end
          if (out_vel_left !== e.lspd) begin
            $error("vel_left: expected %0d, got %0d", signed'(e.lspd), out_vel_left); bad++;
          end
          if (out_vel_right !== e.rspd) begin
            $error("vel_right: expected %0d, got %0d", signed'(e.rspd), out_vel_right);
            bad++;
          end
          if (out_speed_invalid !== e.no_time) begin
            $error("speed_invalid: expected %0d, got %0d", e.no_time, out_speed_invalid);
            bad++;
          end
          errors <= errors + bad;
        end
      end
      if (in_valid && in_ready)
        pose_q.push_back(track(in_left_count, in_right_count, in_elapsed_us));
    end
  end

endmodule

FILE: tb/tb_diff_drive_odometry.sv
// Testbench top for diff_drive_odometry: clock, reset, request stimulus, register writes, verdict.
`timescale 1ns / 1ps
module tb_diff_drive_odometry;
  import ddo_pkg::*;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic signed [31:0] in_left_count = 0;
  logic signed [31:0] in_right_count = 0;
  logic        [23:0] in_elapsed_us = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [31:0] out_pose_x, out_pose_y, out_pose_heading;
  logic signed [31:0] out_vel_left, out_vel_right;
  logic               out_speed_invalid;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic        [2:0]  paddr = 0;
  logic        [31:0] pwdata = 0;
  logic        [31:0] prdata;
  logic               pready;
  int                 pending, errors;

  logic               req_taken = 0;
  bit                 calm = 0;
  bit                 want_hold = 0;
  bit                 held = 0;
  int                 hold_left = 0;
  longint             cycles = 0;
  logic        [31:0] cur_l = 0, cur_r = 0;

  always #1 clk = ~clk;

  diff_drive_odometry dut (.*);

  ddo_checker chk (.*);

  always @(posedge clk) req_taken <= in_valid & in_ready;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd8000000) begin
      $display("tb_diff_drive_odometry NOT OK");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (want_hold && !held) begin
      held = 1;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 0;
    end else begin
      out_ready = calm ? 1'b1 : ($urandom_range(99) >= 30);
    end
  end

  task automatic send(input logic [31:0] l, input logic [31:0] r, input logic [23:0] e);
    if (!calm && $urandom_range(99) < 30) begin
      in_valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1;
    in_left_count = l;
    in_right_count = r;
    in_elapsed_us = e;
    cur_l = l;
    cur_r = r;
    do @(negedge clk); while (!req_taken);
    in_valid = 0;
  endtask

  task automatic reg_write(input logic [2:0] a, input logic [31:0] d);
    psel = 1; pwrite = 1; paddr = a; pwdata = d; penable = 0;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [23:0] pick_elapsed();
    int k;
    k = $urandom_range(99);
    if (k < 5) return 24'd0;
    if (k < 10) return 24'hFFFFFF;
    if (k < 20) return 24'($urandom);
    return 24'($urandom_range(1000, 200000));
  endfunction

  task automatic random_request();
    int          k;
    logic [31:0] dl, dr;
    k = $urandom_range(99);
    dl = 32'($urandom_range(0, 4000)) - 32'd2000;
    dr = 32'($urandom_range(0, 4000)) - 32'd2000;
    if (k < 60) send(cur_l + dl, cur_r + dr, pick_elapsed());
    else if (k < 75) send(cur_l + dl, cur_r + dl, pick_elapsed());
    else if (k < 85) send(cur_l + dl, cur_r - dl, pick_elapsed());
    else send($urandom, $urandom, pick_elapsed());
  endtask

  logic [31:0] mpt_set [6] = '{32'd429497, 32'd0, 32'hFFFFFFFF, 32'd1, 32'd65536, 32'd0};
  logic [31:0] axle_set[6] = '{32'd39322, 32'd0, 32'hFFFFFFFF, 32'd1, 32'd12345, 32'd0};

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: reset registers
    send(0, 0, 0);
    send(100, 100, 1000);
    send(100, 300, 24'hFFFFFF);
    send(400, 0, 1);
    send(32'h7FFFFFFF, 32'h7FFFFFFF, 5000);
    send(32'h80000000, 32'h7FFFFFFF, 0);
    send(32'h80000000, 32'h80000000, 24'hFFFFFF);
    send(32'h00000000, 32'hFFFFFFFF, 20000);
    send(32'hFFFFFFFF, 32'h00000000, 1);
    send(32'h7FFFFFFF, 32'h80000000, 3);
    send(32'h7FFFF000, 32'h80000FFF, 100);
    for (int i = 0; i < 8; i++) send(cur_l + 50, cur_r + 70, 10000);
    send(cur_l - 500, cur_r + 500, 10000);
    send(cur_l + 800, cur_r - 800, 0);

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      if (ph < 6) begin
        reg_write(REG_MPT, mpt_set[ph]);
        reg_write(REG_AXLE, axle_set[ph]);
      end else begin
        reg_write(REG_MPT, $urandom_range(0, 2000000));
        reg_write(REG_AXLE, $urandom_range(0, 200000));
      end
      if (ph == 1) send(cur_l + 10, cur_r + 20, 100);
      calm = (ph == 4);
      if (ph == 2) want_hold = 1;
      for (int i = 0; i < 75; i++) random_request();
    end
    calm = 0;
    drain();
    repeat (600) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_diff_drive_odometry OK");
    end else begin
      $display("tb_diff_drive_odometry NOT OK");
    end
    $finish;
  end

endmodule
